>>> rtl/core/column_definition_parser_defines.svh
// ---------------------------------------------------------------------------
// column definition parser assertion macros
// concurrent checks, compiled out when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef COLUMN_DEFINITION_PARSER_DEFINES_SVH
`define COLUMN_DEFINITION_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define CDP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// expression must never hold
`define CDP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define CDP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define CDP_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> rtl/core/cdp_pkg.sv
// ---------------------------------------------------------------------------
// cdp_pkg
// types, codes and layout constants shared by the column definition parser
// ---------------------------------------------------------------------------
`default_nettype none

package cdp_pkg;

    // default depth of the queue between parser and output stage
    localparam int unsigned CDP_QUEUE_DEPTH = 4;

    // position inside a length-encoded string
    typedef enum logic [1:0]
    {
        PH_PREFIX,
        PH_LENGTH,
        PH_STRING
    } phase_t;

    // result kinds
    typedef enum logic [1:0]
    {
        KIND_BYTE,
        KIND_START,
        KIND_SUMMARY,
        KIND_ERROR
    } kind_t;

    // error codes
    typedef enum logic [1:0]
    {
        ERR_TRUNCATED,
        ERR_TRAILING,
        ERR_TOO_LONG
    } err_t;

    // layout steps
    localparam logic [3:0] STEP_FIRST_FIXED = 4'd6;
    localparam logic [3:0] STEP_CHARSET     = 4'd7;
    localparam logic [3:0] STEP_COL_LENGTH  = 4'd8;
    localparam logic [3:0] STEP_TYPE        = 4'd9;
    localparam logic [3:0] STEP_FLAGS       = 4'd10;
    localparam logic [3:0] STEP_DECIMALS    = 4'd11;
    localparam logic [3:0] STEP_DEFAULT     = 4'd13;
    localparam logic [3:0] STEP_DONE        = 4'd14;

    localparam logic [2:0] FIELD_DEFAULT = 3'd6;

    // length prefix codes
    localparam logic [7:0] PFX_ZERO  = 8'd251;
    localparam logic [7:0] PFX_TWO   = 8'd252;
    localparam logic [7:0] PFX_THREE = 8'd253;
    localparam logic [7:0] PFX_EIGHT = 8'd254;

    // one result item
    typedef struct packed
    {
        kind_t       kind;
        logic [2:0]  field_index;
        logic [7:0]  content_byte;
        logic [23:0] string_length;
        logic [15:0] charset;
        logic [31:0] column_length;
        logic [7:0]  column_type;
        logic [15:0] column_flags;
        logic [7:0]  decimals;
        logic        has_default;
        err_t        error_code;
        logic        last;
    } result_t;

    // results caused by one input beat, second only when two is set
    typedef struct packed
    {
        logic    two;
        result_t first;
        result_t second;
    } job_t;

    // queue status seen by both sides
    typedef struct packed
    {
        logic empty;
        logic full;
    } q_status_t;

    // byte count of a fixed field
    function automatic logic [3:0] fixed_size(input logic [3:0] step);
        logic [3:0] size;
        unique case (step)
            STEP_CHARSET:    size = 4'd2;
            STEP_COL_LENGTH: size = 4'd4;
            STEP_FLAGS:      size = 4'd2;
            default:         size = 4'd1;
        endcase
        return size;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/column_definition_parser.sv
// ---------------------------------------------------------------------------
// column_definition_parser
// parses column definition packets byte by byte into string and summary beats
// ---------------------------------------------------------------------------
//  channel   dir  tdata                   tuser  tlast
//  s_axis    in   data_byte               -      end_of_packet
//  m_axis    out  fields listed at port   kind   last
//
//  a byte beat is accepted every cycle while the job queue has room
//  each byte yields zero, one or two results; the output register sends
//  one result per cycle while m_axis is ready, so a byte with two results fills two beats
//  the queue of QUEUE_DEPTH jobs lets the parser run on while m_axis stalls
//  reset is asynchronous and clears all parser state, no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none

`include "column_definition_parser_defines.svh"

module column_definition_parser
    import cdp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = CDP_QUEUE_DEPTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // data_byte
    input  wire logic         s_axis_tlast,   // end_of_packet
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // field_index, content_byte, string_length, charset, column_length,
    // column_type, column_flags, decimals, has_default, error_code, zero pad
    output logic [119:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // kind
    output logic              m_axis_tlast    // last
);

    q_status_t q_status;
    logic      push, pop;
    job_t      push_data, pop_data;
    result_t   out_item;
    logic      tlast_ok;

    // parser front
    cdp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .data_byte     (s_axis_tdata),
        .end_of_packet (s_axis_tlast),
        .q_status      (q_status),
        .push          (push),
        .push_data     (push_data)
    );

    // job queue
    cdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // output stage
    cdp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    // beat packing
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last;
    assign m_axis_tdata = {2'b00, out_item.error_code, out_item.has_default,
                           out_item.decimals, out_item.column_flags, out_item.column_type,
                           out_item.column_length, out_item.charset,
                           out_item.string_length, out_item.content_byte,
                           out_item.field_index};

    // tlast only on summary and error beats
    assign tlast_ok = (m_axis_tlast ==
                       ((m_axis_tuser == KIND_SUMMARY) || (m_axis_tuser == KIND_ERROR)));

    // checks
    `CDP_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push && q_status.full, "push when full")
    `CDP_ASSERT_NEVER(a_no_pop_when_empty, clk, rst_n, pop && q_status.empty, "pop when empty")
    `CDP_ASSERT_IMPLY(a_last_on_final, clk, rst_n, m_axis_tvalid, tlast_ok, "bad tlast")

endmodule

`default_nettype wire

>>> rtl/core/cdp_front.sv
// ---------------------------------------------------------------------------
// cdp_front
// byte parser: walks the packet layout and queues the results of each beat
// ---------------------------------------------------------------------------
`default_nettype none

module cdp_front
    import cdp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic      end_of_packet,
    input  wire q_status_t q_status,
    output logic           push,
    output job_t           push_data
);

    logic [3:0]  step_reg, step_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  bc_reg, bc_next;
    logic [3:0]  pl_reg, pl_next;
    logic [23:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [23:0] sl_reg, sl_next;
    logic [31:0] fa_reg, fa_next;
    logic [15:0] charset_reg, charset_next;
    logic [31:0] collen_reg, collen_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] flags_reg, flags_next;
    logic [7:0]  dec_reg, dec_next;
    logic        hasdef_reg, hasdef_next;
    logic        discard_reg, discard_next;

    logic        accept;
    logic        in_string, is_fixed, pre_byte;
    logic [2:0]  fld;
    logic [3:0]  pfx_count;
    logic [23:0] acc_upd;
    logic        ovf_upd;
    logic [3:0]  pl_upd, bc_inc;
    logic        last_prefix;
    logic [23:0] start_len, sl_upd;
    logic        do_start, do_toolong, do_trailing, do_byte, do_finish, failed;
    logic [31:0] fa_upd;
    logic        fixed_done;
    logic [3:0]  step_after;
    phase_t      phase_after;
    logic [15:0] charset_upd;
    logic [31:0] collen_upd;
    logic [7:0]  type_upd, dec_upd;
    logic [15:0] flags_upd;
    logic        hasdef_upd, summary_ok;
    logic        prim_valid, eop_valid;
    result_t     prim_item, eop_item;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // classify the beat against the current layout position
    always_comb
    begin
        in_string   = (step_reg < STEP_FIRST_FIXED) || (step_reg == STEP_DEFAULT);
        is_fixed    = !in_string && (step_reg < STEP_DONE);
        do_trailing = (step_reg >= STEP_DONE);
        pre_byte    = (data_byte == PFX_TWO) || (data_byte == PFX_THREE) ||
                      (data_byte == PFX_EIGHT);
        fld         = (step_reg == STEP_DEFAULT) ? FIELD_DEFAULT : step_reg[2:0];
        unique case (data_byte)
            PFX_TWO:   pfx_count = 4'd2;
            PFX_THREE: pfx_count = 4'd3;
            default:   pfx_count = 4'd8;
        endcase

        // multi-byte length prefix, bytes beyond the third must be zero
        bc_inc      = bc_reg + 4'd1;
        acc_upd     = (bc_reg < 4'd3) ? (acc_reg | (24'(data_byte) << {bc_reg[1:0], 3'b000}))
                                      : acc_reg;
        ovf_upd     = ovf_reg || ((bc_reg >= 4'd3) && (data_byte != 8'd0));
        pl_upd      = pl_reg - 4'd1;
        last_prefix = (pl_upd == 4'd0);

        start_len   = (phase_reg == PH_PREFIX) ?
                      ((data_byte == PFX_ZERO) ? 24'd0 : 24'(data_byte)) : acc_upd;
        do_start    = in_string &&
                      (((phase_reg == PH_PREFIX) && !pre_byte) ||
                       ((phase_reg == PH_LENGTH) && last_prefix && !ovf_upd));
        do_toolong  = in_string && (phase_reg == PH_LENGTH) && last_prefix && ovf_upd;
        do_byte     = in_string && (phase_reg == PH_STRING);
        sl_upd      = sl_reg - 24'd1;
        do_finish   = (do_start && (start_len == 24'd0)) || (do_byte && (sl_upd == 24'd0));
        failed      = do_trailing || do_toolong;

        // fixed little-endian fields
        fa_upd      = fa_reg | (32'(data_byte) << {bc_reg[1:0], 3'b000});
        fixed_done  = is_fixed && (bc_inc >= fixed_size(step_reg));

        // layout position after this beat
        phase_after = phase_reg;
        if (in_string && (phase_reg == PH_PREFIX) && pre_byte)
            phase_after = PH_LENGTH;
        if (do_start)
            phase_after = PH_STRING;
        if (do_finish)
            phase_after = PH_PREFIX;
        step_after = step_reg;
        if (do_finish)
            step_after = (step_reg == STEP_DEFAULT) ? STEP_DONE : step_reg + 4'd1;
        else if (fixed_done)
            step_after = step_reg + 4'd1;

        // saved summary fields after this beat
        charset_upd = (fixed_done && (step_reg == STEP_CHARSET)) ? fa_upd[15:0] : charset_reg;
        collen_upd  = (fixed_done && (step_reg == STEP_COL_LENGTH)) ? fa_upd : collen_reg;
        type_upd    = (fixed_done && (step_reg == STEP_TYPE)) ? fa_upd[7:0] : type_reg;
        flags_upd   = (fixed_done && (step_reg == STEP_FLAGS)) ? fa_upd[15:0] : flags_reg;
        dec_upd     = (fixed_done && (step_reg == STEP_DECIMALS)) ? fa_upd[7:0] : dec_reg;
        hasdef_upd  = hasdef_reg || (do_finish && (step_reg == STEP_DEFAULT));
        summary_ok  = (step_after == STEP_DONE) ||
                      ((step_after == STEP_DEFAULT) && (phase_after == PH_PREFIX));
    end

    // next state: end of packet always restarts the layout
    always_comb
    begin
        step_next    = step_reg;
        phase_next   = phase_reg;
        bc_next      = bc_reg;
        pl_next      = pl_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        sl_next      = sl_reg;
        fa_next      = fa_reg;
        charset_next = charset_reg;
        collen_next  = collen_reg;
        type_next    = type_reg;
        flags_next   = flags_reg;
        dec_next     = dec_reg;
        hasdef_next  = hasdef_reg;
        discard_next = discard_reg;
        if (accept && end_of_packet)
        begin
            step_next    = '0;
            phase_next   = PH_PREFIX;
            bc_next      = '0;
            pl_next      = '0;
            acc_next     = '0;
            ovf_next     = 1'b0;
            sl_next      = '0;
            fa_next      = '0;
            charset_next = '0;
            collen_next  = '0;
            type_next    = '0;
            flags_next   = '0;
            dec_next     = '0;
            hasdef_next  = 1'b0;
            discard_next = 1'b0;
        end
        else if (accept && !discard_reg)
        begin
            step_next    = step_after;
            phase_next   = phase_after;
            discard_next = failed;
            if (in_string && (phase_reg == PH_PREFIX))
            begin
                bc_next  = '0;
                acc_next = '0;
                ovf_next = 1'b0;
                if (pre_byte)
                    pl_next = pfx_count;
            end
            if (in_string && (phase_reg == PH_LENGTH))
            begin
                bc_next  = bc_inc;
                pl_next  = pl_upd;
                acc_next = acc_upd;
                ovf_next = ovf_upd;
            end
            if (do_start && (start_len != 24'd0))
                sl_next = start_len;
            if (do_byte)
                sl_next = sl_upd;
            if (is_fixed)
            begin
                bc_next = fixed_done ? 4'd0 : bc_inc;
                fa_next = fixed_done ? 32'd0 : fa_upd;
            end
            charset_next = charset_upd;
            collen_next  = collen_upd;
            type_next    = type_upd;
            flags_next   = flags_upd;
            dec_next     = dec_upd;
            hasdef_next  = hasdef_upd;
        end
    end

    // results of the beat, packed into one queue entry
    always_comb
    begin
        prim_valid = !discard_reg && (do_trailing || do_toolong || do_start || do_byte);
        prim_item  = '0;
        if (do_trailing)
        begin
            prim_item.kind       = KIND_ERROR;
            prim_item.error_code = ERR_TRAILING;
            prim_item.last       = 1'b1;
        end
        else if (do_toolong)
        begin
            prim_item.kind       = KIND_ERROR;
            prim_item.error_code = ERR_TOO_LONG;
            prim_item.last       = 1'b1;
        end
        else if (do_start)
        begin
            prim_item.kind          = KIND_START;
            prim_item.field_index   = fld;
            prim_item.string_length = start_len;
        end
        else
        begin
            prim_item.kind         = KIND_BYTE;
            prim_item.field_index  = fld;
            prim_item.content_byte = data_byte;
        end

        eop_valid = !discard_reg && end_of_packet && !failed;
        eop_item  = '0;
        eop_item.last = 1'b1;
        if (summary_ok)
        begin
            eop_item.kind          = KIND_SUMMARY;
            eop_item.charset       = charset_upd;
            eop_item.column_length = collen_upd;
            eop_item.column_type   = type_upd;
            eop_item.column_flags  = flags_upd;
            eop_item.decimals      = dec_upd;
            eop_item.has_default   = hasdef_upd;
        end
        else
        begin
            eop_item.kind       = KIND_ERROR;
            eop_item.error_code = ERR_TRUNCATED;
        end

        push      = accept && (prim_valid || eop_valid);
        push_data = '0;
        if (prim_valid)
        begin
            push_data.first  = prim_item;
            push_data.second = eop_item;
            push_data.two    = eop_valid;
        end
        else
        begin
            push_data.first = eop_item;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            phase_reg   <= PH_PREFIX;
            bc_reg      <= '0;
            pl_reg      <= '0;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            sl_reg      <= '0;
            fa_reg      <= '0;
            charset_reg <= '0;
            collen_reg  <= '0;
            type_reg    <= '0;
            flags_reg   <= '0;
            dec_reg     <= '0;
            hasdef_reg  <= 1'b0;
            discard_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            bc_reg      <= bc_next;
            pl_reg      <= pl_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            sl_reg      <= sl_next;
            fa_reg      <= fa_next;
            charset_reg <= charset_next;
            collen_reg  <= collen_next;
            type_reg    <= type_next;
            flags_reg   <= flags_next;
            dec_reg     <= dec_next;
            hasdef_reg  <= hasdef_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/cdp_queue.sv
// ---------------------------------------------------------------------------
// cdp_queue
// short register queue of result jobs between parser and output stage
// ---------------------------------------------------------------------------
`default_nettype none

module cdp_queue
    import cdp_pkg::*;
#(
    parameter int unsigned DEPTH = CDP_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    input  wire logic pop,
    output job_t      pop_data,
    output q_status_t q_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign pop_data       = entry_reg[rd_reg];
    assign q_status.empty = (cnt_reg == CNT_W'(0));
    assign q_status.full  = (cnt_reg == CNT_W'(DEPTH));

    // pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> rtl/core/cdp_back.sv
// ---------------------------------------------------------------------------
// cdp_back
// output stage: splits each job into result beats behind an output register
// ---------------------------------------------------------------------------
`default_nettype none

module cdp_back
    import cdp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_status,
    input  wire job_t      pop_data,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output result_t        out_item
);

    logic    out_valid_reg, out_valid_next;
    result_t out_item_reg, out_item_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_item_reg, pend_item_next;
    logic    advance;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign advance   = !out_valid_reg || out_ready;

    // held second result goes first, otherwise take a new job
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        pend_valid_next = pend_valid_reg;
        pend_item_next  = pend_item_reg;
        pop             = 1'b0;
        if (advance)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = pend_item_reg;
                pend_valid_next = 1'b0;
            end
            else if (!q_status.empty)
            begin
                pop             = 1'b1;
                out_valid_next  = 1'b1;
                out_item_next   = pop_data.first;
                pend_valid_next = pop_data.two;
                pend_item_next  = pop_data.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        pend_item_reg <= pend_item_next;
    end

endmodule

`default_nettype wire
